FILE: rtl/core/npr_pkg.sv
// Shared types, constants and the arctangent table for the nearest point search.
// No dependencies; every other file of the block but npr_ram imports this package.
package npr_pkg;

    localparam int MAX_POINTS_DEF   = 1024;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [31:0] EARTH_R_M   = 32'd6371000;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [29:0] DEG_SPAN    = 30'd360000000;
    localparam logic [60:0] DEG_HALF    = 61'd180000000;
    // fraction part of 2^32 / 360000000, scaled by 2^32 and rounded down
    localparam logic [31:0] ANG_FRAC    = 32'd3996315504;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef logic signed [23:0] coord_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [62:0] id;
        coord_t      x;
        coord_t      y;
        coord_t      z;
    } job_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/nearest_point_within_radius.sv
// Top level of the nearest point search: config register, front end, queue, back end.
// Uses npr_pkg, npr_front, npr_queue and npr_back.
//
// Commands are taken while busy is low. Clear holds busy until the queue takes it; a
// load or a query holds it while the front end converts both angles, mostly in the
// shared CORDIC stage run once per angle, and longer while the two-entry queue is full.
// A query then holds the back end while it scans the table, one stored point per cycle
// through the single table read port; an empty table is answered without a scan. The
// front end may convert the next command meanwhile. Each query gives one result on
// done for exactly one cycle; the receiver cannot stall it, so take it when shown.
module nearest_point_within_radius
    import npr_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [62:0]        point_id,
    input  logic signed [27:0] latitude,
    input  logic signed [28:0] longitude,
    input  logic               cfg_we,
    input  logic [23:0]        cfg_wdata,
    output logic               done,
    output logic               found,
    output logic [62:0]        nearest_id
);

    logic [23:0] dist_limit_reg;
    logic        push, q_full, q_empty, pop;
    job_t        push_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_limit_reg <= 24'd100;
        end
        else if (cfg_we)
        begin
            dist_limit_reg <= cfg_wdata;
        end
    end

    npr_front #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .point_id (point_id),
        .latitude (latitude),
        .longitude(longitude),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    npr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .head_job(head_job)
    );

    npr_back #(
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_job  (head_job),
        .pop       (pop),
        .dist_limit(dist_limit_reg),
        .done      (done),
        .found     (found),
        .nearest_id(nearest_id)
    );

endmodule

FILE: rtl/core/npr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/npr_queue.sv
// Two-entry job queue between the conversion front end and the table back end.
// Depends on npr_pkg for job_t.
module npr_queue
    import npr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

FILE: rtl/core/npr_front.sv
// Front end: accepts commands, turns latitude and longitude into x, y, z metres
// with a reciprocal angle scaler, a shared CORDIC stage and one multiplier. Uses npr_pkg.
module npr_front
    import npr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [62:0]        point_id,
    input  logic signed [27:0] latitude,
    input  logic signed [28:0] longitude,
    output logic               push,
    output job_t               push_job,
    input  logic               q_full
);

    typedef enum logic [2:0] {F_IDLE, F_DIV, F_FIX, F_ANG, F_ROT, F_MUL, F_PUSH} fstate_t;

    fstate_t            state_reg;
    logic [1:0]         op_reg;
    logic [62:0]        id_reg;
    logic signed [28:0] lon_reg;
    logic               sel_reg;
    logic [28:0]        mag_reg;
    logic [31:0]        quo_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic               flip_reg;
    logic signed [31:0] clat_reg, slat_reg, clon_reg, slon_reg, p1_reg, p2_reg;
    coord_t             x_reg, y_reg, z_reg;

    logic [28:0]        lat_mag, lon_mag;
    logic [60:0]        ang_fprod;
    logic [63:0]        ang_round;
    logic [31:0]        ang_est;
    logic [32:0]        q_inc;
    logic [61:0]        ang_chk, ang_num;
    logic               ang_fix;
    logic [31:0]        ang;
    logic [31:0]        ang_adj;
    logic signed [33:0] dx, dy;
    logic signed [32:0] atan_v;
    logic signed [33:0] fin_c, fin_s;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod, prod_rnd;

    assign lat_mag = latitude[27] ? 29'(-$signed({latitude[27], latitude})) : 29'(latitude);
    assign lon_mag = lon_reg[28] ? 29'(-lon_reg) : 29'(lon_reg);

    // Binary angle of the magnitude: estimate by reciprocal multiply, at most one low.
    assign ang_fprod = {32'd0, mag_reg} * {29'd0, ANG_FRAC};
    assign ang_round = {3'b000, ang_fprod} + 64'h0000_0000_8000_0000;
    assign ang_est   = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1)
                     + {3'b000, mag_reg} + ang_round[63:32];

    // Step the estimate up when the next quotient still fits the biased numerator.
    assign q_inc   = {1'b0, quo_reg} + 33'd1;
    assign ang_chk = {29'd0, q_inc} * {32'd0, DEG_SPAN};
    assign ang_num = {1'b0, mag_reg, 32'd0} + {1'b0, DEG_HALF};
    assign ang_fix = (ang_chk <= ang_num);

    assign ang     = neg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign ang_adj = (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) ? (ang + 32'h80000000) : ang;

    assign dx     = cy_reg >>> cnt_reg[4:0];
    assign dy     = cx_reg >>> cnt_reg[4:0];
    assign atan_v = $signed({1'b0, atan_lut(cnt_reg[4:0])});

    always_comb
    begin
        if (cz_reg >= 0)
        begin
            fin_c = cx_reg - dx;
            fin_s = cy_reg + dy;
        end
        else
        begin
            fin_c = cx_reg + dx;
            fin_s = cy_reg - dy;
        end
    end

    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    begin mul_a = clat_reg; mul_b = clon_reg; end
            3'd1:    begin mul_a = clat_reg; mul_b = slon_reg; end
            3'd2:    begin mul_a = p1_reg;   mul_b = $signed(EARTH_R_M); end
            3'd3:    begin mul_a = p2_reg;   mul_b = $signed(EARTH_R_M); end
            default: begin mul_a = slat_reg; mul_b = $signed(EARTH_R_M); end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_rnd = (prod + 64'sd536870912) >>> 30;

    assign busy           = (state_reg != F_IDLE);
    assign push           = (state_reg == F_PUSH) && !q_full;
    assign push_job.op    = op_reg;
    assign push_job.id    = id_reg;
    assign push_job.x     = x_reg;
    assign push_job.y     = y_reg;
    assign push_job.z     = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        op_reg  <= opcode;
                        id_reg  <= point_id;
                        lon_reg <= longitude;
                        sel_reg <= 1'b0;
                        mag_reg <= lat_mag;
                        neg_reg <= latitude[27];
                        if (opcode == OP_LOAD || opcode == OP_QUERY)
                        begin
                            state_reg <= F_DIV;
                        end
                        else if (opcode == OP_CLEAR)
                        begin
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_DIV:
                begin
                    quo_reg   <= ang_est;
                    state_reg <= F_FIX;
                end
                F_FIX:
                begin
                    quo_reg   <= quo_reg + {31'd0, ang_fix};
                    state_reg <= F_ANG;
                end
                F_ANG:
                begin
                    cx_reg    <= $signed(CORDIC_GAIN);
                    cy_reg    <= '0;
                    cz_reg    <= 33'($signed(ang_adj));
                    flip_reg  <= (ang != ang_adj);
                    cnt_reg   <= '0;
                    state_reg <= F_ROT;
                end
                F_ROT:
                begin
                    cx_reg  <= fin_c;
                    cy_reg  <= fin_s;
                    cz_reg  <= (cz_reg >= 0) ? (cz_reg - atan_v) : (cz_reg + atan_v);
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CORDIC_STEPS - 1))
                    begin
                        if (!sel_reg)
                        begin
                            clat_reg  <= flip_reg ? 32'(-fin_c) : 32'(fin_c);
                            slat_reg  <= flip_reg ? 32'(-fin_s) : 32'(fin_s);
                            sel_reg   <= 1'b1;
                            mag_reg   <= lon_mag;
                            neg_reg   <= lon_reg[28];
                            cnt_reg   <= '0;
                            state_reg <= F_DIV;
                        end
                        else
                        begin
                            clon_reg  <= flip_reg ? 32'(-fin_c) : 32'(fin_c);
                            slon_reg  <= flip_reg ? 32'(-fin_s) : 32'(fin_s);
                            cnt_reg   <= '0;
                            state_reg <= F_MUL;
                        end
                    end
                end
                F_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    case (cnt_reg[2:0])
                        3'd0:    p1_reg <= prod_rnd[31:0];
                        3'd1:    p2_reg <= prod_rnd[31:0];
                        3'd2:    x_reg  <= prod_rnd[23:0];
                        3'd3:    y_reg  <= prod_rnd[23:0];
                        default:
                        begin
                            z_reg     <= prod_rnd[23:0];
                            state_reg <= F_PUSH;
                        end
                    endcase
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/npr_back.sv
// Back end: holds the point table in RAM, runs clears and loads, and scans it for queries.
// Uses npr_pkg and npr_ram.
module npr_back
    import npr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        head_job,
    output logic        pop,
    input  logic [23:0] dist_limit,
    output logic        done,
    output logic        found,
    output logic [62:0] nearest_id
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = 63 + 3 * 24;

    typedef enum logic [1:0] {B_IDLE, B_SCAN, B_FINAL} bstate_t;

    bstate_t            state_reg;
    logic [CW-1:0]      count_reg, rd_idx_reg;
    coord_t             qx_reg, qy_reg, qz_reg;
    logic               s1_v_reg, s2_v_reg;
    logic [47:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [62:0]        id2_reg;
    logic [49:0]        best_reg;
    logic [62:0]        best_id_reg;
    logic               any_reg;
    logic [47:0]        lim_reg;
    logic               done_reg, found_reg;
    logic [62:0]        out_id_reg;

    logic               wr_en;
    logic [DW-1:0]      wdata, rdata;
    coord_t             rx, ry, rz;
    logic signed [24:0] dx, dy, dz;
    logic signed [49:0] sqx, sqy, sqz;
    logic [49:0]        dsum;
    logic               issue;

    assign pop   = (state_reg == B_IDLE) && !q_empty;
    assign wr_en = pop && (head_job.op == OP_LOAD) && (count_reg < CW'(MAX_POINTS));
    assign wdata = {head_job.id, head_job.x, head_job.y, head_job.z};
    assign issue = (state_reg == B_SCAN) && (rd_idx_reg < count_reg);

    npr_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .clk  (clk),
        .we   (wr_en),
        .waddr(count_reg[AW-1:0]),
        .wdata(wdata),
        .raddr(rd_idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    assign rx   = rdata[71:48];
    assign ry   = rdata[47:24];
    assign rz   = rdata[23:0];
    assign dx   = 25'(qx_reg) - 25'(rx);
    assign dy   = 25'(qy_reg) - 25'(ry);
    assign dz   = 25'(qz_reg) - 25'(rz);
    assign sqx  = dx * dx;
    assign sqy  = dy * dy;
    assign sqz  = dz * dz;
    assign dsum = 50'(sqx_reg) + 50'(sqy_reg) + 50'(sqz_reg);

    assign done       = done_reg;
    assign found      = found_reg;
    assign nearest_id = out_id_reg;

    always_ff @(posedge clk)
    begin
        lim_reg <= dist_limit * dist_limit;
        sqx_reg <= sqx[47:0];
        sqy_reg <= sqy[47:0];
        sqz_reg <= sqz[47:0];
        id2_reg <= rdata[134:72];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            any_reg    <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            out_id_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        case (head_job.op)
                            OP_CLEAR: count_reg <= '0;
                            OP_LOAD:
                            begin
                                if (wr_en)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            OP_QUERY:
                            begin
                                qx_reg     <= head_job.x;
                                qy_reg     <= head_job.y;
                                qz_reg     <= head_job.z;
                                rd_idx_reg <= '0;
                                any_reg    <= 1'b0;
                                if (count_reg == '0)
                                begin
                                    done_reg   <= 1'b1;
                                    found_reg  <= 1'b0;
                                    out_id_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= B_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                B_SCAN:
                begin
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                    end
                    // strict compare keeps the earliest point on equal distance
                    if (s2_v_reg && (!any_reg || dsum < best_reg))
                    begin
                        best_reg    <= dsum;
                        best_id_reg <= id2_reg;
                        any_reg     <= 1'b1;
                    end
                    if (!issue && !s1_v_reg && !s2_v_reg)
                    begin
                        state_reg <= B_FINAL;
                    end
                end
                B_FINAL:
                begin
                    done_reg   <= 1'b1;
                    found_reg  <= any_reg && (best_reg <= {2'b00, lim_reg});
                    out_id_reg <= (any_reg && (best_reg <= {2'b00, lim_reg})) ? best_id_reg : '0;
                    state_reg  <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table depth");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg |-> (state_reg == B_SCAN))
        else $error("scan pipeline active outside a scan");

    a_miss_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |-> (out_id_reg == '0))
        else $error("not-found result carries an id");

    a_final_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FINAL) |=> done_reg)
        else $error("finished scan gave no result");

endmodule

FILE: sim/tb_nearest_point_within_radius.sv
// Testbench for nearest_point_within_radius: random and directed clear/load/query traffic.
// Depends on npr_pkg and the block's RTL; a scoreboard class predicts every query answer.
module tb_nearest_point_within_radius;
    import npr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 2 * (62 + 24) + 6 + TABLE_DEPTH + 200;
    localparam int WATCHDOG_LIMIT = 20000;

    class nearest_scoreboard;
        logic signed [23:0] tab_x[TABLE_DEPTH];
        logic signed [23:0] tab_y[TABLE_DEPTH];
        logic signed [23:0] tab_z[TABLE_DEPTH];
        logic [62:0]        tab_id[TABLE_DEPTH];
        int                 count;
        logic [23:0]        radius;
        logic [63:0]        answers[$];
        int                 errors;
        logic [31:0]        atan_steps[24] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

        function new();
            count = 0;
            radius = 24'd100;
            errors = 0;
        endfunction

        function logic [31:0] binary_angle(longint udeg);
            longint q;
            if (udeg >= 0)
                q = (udeg * 64'sd4294967296 + 64'sd180000000) / 64'sd360000000;
            else
                q = -((-udeg * 64'sd4294967296 + 64'sd180000000) / 64'sd360000000);
            return q[31:0];
        endfunction

        function void rotate(logic [31:0] ang, output longint c, output longint s);
            longint x, y, z, dx, dy;
            bit flip;
            x = 652032874;
            y = 0;
            flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
            if (flip)
                ang = ang + 32'h80000000;
            z = longint'($signed(ang));
            for (int i = 0; i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx; y = y + dy; z = z - longint'(atan_steps[i]);
                end
                else
                begin
                    x = x + dx; y = y - dy; z = z + longint'(atan_steps[i]);
                end
            end
            if (flip)
            begin
                x = -x; y = -y;
            end
            c = x;
            s = y;
        endfunction

        function longint q30_mul(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function void geo_to_xyz(logic signed [27:0] lat, logic signed [28:0] lon,
                                 output longint x, output longint y, output longint z);
            longint clat, slat, clon, slon;
            rotate(binary_angle(longint'(lat)), clat, slat);
            rotate(binary_angle(longint'(lon)), clon, slon);
            x = q30_mul(q30_mul(clat, clon), 6371000);
            y = q30_mul(q30_mul(clat, slon), 6371000);
            z = q30_mul(slat, 6371000);
        endfunction

        function void set_radius(logic [23:0] v);
            radius = v;
        endfunction

        function bit pending();
            return answers.size() != 0;
        endfunction

        // Update the table or predict one answer for an accepted transaction.
        function void note(logic [1:0] op, logic [62:0] id,
                           logic signed [27:0] lat, logic signed [28:0] lon);
            longint x, y, z, dx, dy, dz, d, best;
            logic [62:0] best_id;
            if (op == OP_CLEAR)
                count = 0;
            else if (op == OP_LOAD)
            begin
                if (count < TABLE_DEPTH)
                begin
                    geo_to_xyz(lat, lon, x, y, z);
                    tab_x[count] = x[23:0];
                    tab_y[count] = y[23:0];
                    tab_z[count] = z[23:0];
                    tab_id[count] = id;
                    count++;
                end
            end
            else if (op == OP_QUERY)
            begin
                geo_to_xyz(lat, lon, x, y, z);
                best = 0;
                best_id = '0;
                for (int i = 0; i < count; i++)
                begin
                    dx = x - longint'(tab_x[i]);
                    dy = y - longint'(tab_y[i]);
                    dz = z - longint'(tab_z[i]);
                    d = dx * dx + dy * dy + dz * dz;
                    if (i == 0 || d < best)
                    begin
                        best = d;
                        best_id = tab_id[i];
                    end
                end
                if (count > 0 && best <= longint'(radius) * longint'(radius))
                    answers.push_back({1'b1, best_id});
                else
                    answers.push_back(64'd0);
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic got_found, logic [62:0] got_id);
            logic [63:0] exp_ans;
            if (answers.size() == 0)
                report("answer with no query outstanding");
            else
            begin
                exp_ans = answers.pop_front();
                if (got_found !== exp_ans[63])
                    report($sformatf("found %0b, expected %0b", got_found, exp_ans[63]));
                if (got_id !== exp_ans[62:0])
                    report($sformatf("nearest_id %h, expected %h", got_id, exp_ans[62:0]));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         opcode = OP_CLEAR;
    logic [62:0]        point_id = '0;
    logic signed [27:0] latitude = '0;
    logic signed [28:0] longitude = '0;
    logic               cfg_we = 1'b0;
    logic [23:0]        cfg_wdata = '0;
    logic               done;
    logic               found;
    logic [62:0]        nearest_id;

    nearest_scoreboard sb = new();
    int                quiet_cycles = 0;
    logic signed [27:0] saved_lat[$];
    logic signed [28:0] saved_lon[$];

    nearest_point_within_radius i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .point_id   (point_id),
        .latitude   (latitude),
        .longitude  (longitude),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .found      (found),
        .nearest_id (nearest_id)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(found, nearest_id);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task send(logic [1:0] op, logic [62:0] id, logic signed [27:0] lat,
              logic signed [28:0] lon, bit allow_idle);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        opcode <= op;
        point_id <= id;
        latitude <= lat;
        longitude <= lon;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note(op, id, lat, lon);
        if (op == OP_CLEAR)
        begin
            saved_lat.delete();
            saved_lon.delete();
        end
        else if (op == OP_LOAD && saved_lat.size() < TABLE_DEPTH)
        begin
            saved_lat.push_back(lat);
            saved_lon.push_back(lon);
        end
    endtask

    // Drop start, drain all answers, then let a trailing load finish before the write.
    task write_radius(logic [23:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        sb.set_radius(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function logic [62:0] rand_id();
        return 63'({$urandom(), $urandom()});
    endfunction

    task send_near(logic [1:0] op, bit allow_idle);
        int k;
        int span;
        k = $urandom_range(0, saved_lat.size() - 1);
        span = ($urandom_range(0, 1) == 0) ? 0 : 2000;
        send(op, rand_id(),
             28'(saved_lat[k] + $signed($urandom_range(0, 2 * span)) - span),
             29'(saved_lon[k] + $signed($urandom_range(0, 2 * span)) - span), allow_idle);
    endtask

    task run_random(int n, bit allow_idle);
        int r;
        logic signed [27:0] lat;
        logic signed [28:0] lon;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            lat = 28'($urandom_range(0, 180000000) - 90000000);
            lon = 29'($urandom_range(0, 360000000) - 180000000);
            if (r < 7)
                send(OP_CLEAR, rand_id(), lat, lon, allow_idle);
            else if (r < 45)
            begin
                if (saved_lat.size() > 0 && r < 25)
                    send_near(OP_LOAD, allow_idle);
                else
                    send(OP_LOAD, rand_id(), lat, lon, allow_idle);
            end
            else if (r < 93)
            begin
                if (saved_lat.size() > 0 && r < 80)
                    send_near(OP_QUERY, allow_idle);
                else
                    send(OP_QUERY, rand_id(), lat, lon, allow_idle);
            end
            else if (r < 96)
                send(OP_UNUSED, rand_id(), 28'($urandom()), 29'($urandom()), allow_idle);
            else
                send(($urandom_range(0, 1) == 0) ? OP_LOAD : OP_QUERY, rand_id(),
                     28'($urandom()), 29'($urandom()), allow_idle);
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, extremes, ties, wrapped angles, unused opcode.
        send(OP_QUERY, '0, '0, '0, 1'b0);
        send(OP_LOAD, '0, 28'sd90000000, 29'sd180000000, 1'b0);
        send(OP_LOAD, '1, -28'sd90000000, -29'sd180000000, 1'b0);
        send(OP_LOAD, 63'd7, '0, '0, 1'b0);
        send(OP_LOAD, 63'd8, '0, '0, 1'b0);
        send(OP_LOAD, 63'h5555_5555_5555_5555, 28'h800_0000, 29'h0FFF_FFFF, 1'b0);
        send(OP_LOAD, 63'h2AAA_AAAA_AAAA_AAAA, 28'h7FF_FFFF, 29'h1000_0000, 1'b0);
        send(OP_QUERY, '0, '0, '0, 1'b0);
        send(OP_QUERY, '0, 28'sd90000000, 29'sd180000000, 1'b0);
        send(OP_QUERY, '0, -28'sd90000000, -29'sd180000000, 1'b0);
        send(OP_QUERY, '0, 28'h800_0000, 29'h0FFF_FFFF, 1'b0);
        send(OP_QUERY, '0, 28'h7FF_FFFF, 29'h1000_0000, 1'b0);
        send(OP_QUERY, '0, 28'sd450, 29'sd300, 1'b0);
        send(OP_QUERY, '0, 28'sd45000000, 29'sd90000000, 1'b0);
        send(OP_UNUSED, '1, '1, '1, 1'b0);
        send(OP_CLEAR, '0, '0, '0, 1'b0);
        send(OP_QUERY, '0, '0, '0, 1'b0);

        run_random(100, 1'b1);
        write_radius(24'd0);
        run_random(60, 1'b1);
        write_radius(24'hFFFFFF);
        run_random(60, 1'b1);

        write_radius(24'd5000);
        send(OP_CLEAR, '0, '0, '0, 1'b1);
        run_random(40, 1'b1);

        write_radius(24'd12742000);
        run_random(80, 1'b1);
        write_radius(24'($urandom_range(1, 20000)));
        run_random(100, 1'b1);
        write_radius(24'($urandom_range(20, 3000)));
        run_random(80, 1'b0);

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && !sb.pending())
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/npr_pkg.sv
rtl/core/npr_ram.sv
rtl/core/npr_queue.sv
rtl/core/npr_front.sv
rtl/core/npr_back.sv
rtl/core/nearest_point_within_radius.sv
sim/tb_nearest_point_within_radius.sv
